FILE: hdl/two_way_traffic_light_controller_assert.svh
// Assertion macros for the two-way traffic light controller.
`ifndef TWO_WAY_TRAFFIC_LIGHT_CONTROLLER_ASSERT_SVH
`define TWO_WAY_TRAFFIC_LIGHT_CONTROLLER_ASSERT_SVH

`ifndef SYNTH
// Check that prop holds at every rising clock edge out of reset.
`define TWTLC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Check that cond never holds out of reset.
`define TWTLC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define TWTLC_ASSERT(lbl, clk, rst_n, prop)
`define TWTLC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: hdl/twtlc_pkg.sv
// Shared types, codes and helpers of the two-way traffic light controller.
`timescale 1ns / 1ps

package twtlc_pkg;

	// Field widths
	localparam int unsigned TotalW  = 7;
	localparam int unsigned YellowW = 4;
	localparam int unsigned LampW   = 6;
	localparam int unsigned DigitW  = 4;
	localparam int unsigned KindW   = 2;
	localparam int unsigned IdxW    = 2;

	typedef logic [TotalW-1:0]  total_t;
	typedef logic [YellowW-1:0] yellow_t;
	typedef logic [LampW-1:0]   lamp_t;
	typedef logic [DigitW-1:0]  digit_t;
	typedef logic [KindW-1:0]   kind_code_t;
	typedef logic [IdxW-1:0]    reg_idx_t;

	// Input item kinds; code 3 means nothing
	typedef enum logic [KindW-1:0] {
		KIND_TICK  = 2'd0,
		KIND_START = 2'd1,
		KIND_PRESS = 2'd2
	} kind_t;

	// Configuration register indexes
	typedef enum logic [IdxW-1:0] {
		REG_SOUTH_TOTAL  = 2'd0,
		REG_WEST_TOTAL   = 2'd1,
		REG_YELLOW_TICKS = 2'd2
	} reg_sel_t;

	// Lamp patterns: bits 5..3 south G,Y,R; bits 2..0 west G,Y,R
	localparam lamp_t LAMP_OFF      = 6'b000000;
	localparam lamp_t LAMP_S_GREEN  = 6'b100001;
	localparam lamp_t LAMP_S_YELLOW = 6'b010001;
	localparam lamp_t LAMP_W_GREEN  = 6'b001100;
	localparam lamp_t LAMP_W_YELLOW = 6'b001010;

	// Reset values of the configuration registers
	localparam total_t  SOUTH_TOTAL_RST  = 7'd15;
	localparam total_t  WEST_TOTAL_RST   = 7'd23;
	localparam yellow_t YELLOW_TICKS_RST = 4'd3;

	// One result item
	typedef struct packed {
		lamp_t  lamps;
		digit_t tens_digit;
		digit_t units_digit;
	} out_item_t;

	// Pick the lamp pattern of the running direction
	function automatic lamp_t lamp_code(input logic west, input logic green);
		lamp_t code;
		if (west) begin
			code = green ? LAMP_W_GREEN : LAMP_W_YELLOW;
		end else begin
			code = green ? LAMP_S_GREEN : LAMP_S_YELLOW;
		end
		return code;
	endfunction

	// Tens digit by reciprocal multiply: (x * 205) >> 11 is exact below 1029
	function automatic digit_t tens_of(input total_t x);
		logic [14:0] prod;
		prod = 15'(x) * 15'd205;
		return prod[14:11];
	endfunction

	// Units digit as the remainder after the tens digit
	function automatic digit_t units_of(input total_t x);
		total_t tens_x10;
		total_t rem;
		tens_x10 = total_t'(tens_of(x)) * total_t'(10);
		rem      = x - tens_x10;
		return rem[DigitW-1:0];
	endfunction

endpackage

FILE: hdl/twtlc_if.sv
// Valid/ready channel interfaces for event input and display output.
`timescale 1ns / 1ps

interface twtlc_in_if;
	logic                   valid;
	logic                   ready;
	twtlc_pkg::kind_code_t  kind;
	logic                   manual_enable;

	modport source (output valid, output kind, output manual_enable, input ready);
	modport sink   (input valid, input kind, input manual_enable, output ready);
endinterface

interface twtlc_out_if;
	logic                valid;
	logic                ready;
	twtlc_pkg::lamp_t    lamps;
	twtlc_pkg::digit_t   tens_digit;
	twtlc_pkg::digit_t   units_digit;

	modport source (output valid, output lamps, output tens_digit, output units_digit,
		input ready);
	modport sink   (input valid, input lamps, input tens_digit, input units_digit,
		output ready);
endinterface

FILE: hdl/two_way_traffic_light_controller.sv
// Two-way traffic light controller: phase sequencer with lamp and countdown output.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   kind, manual_enable
//   out_ch   out  valid/ready   lamps, tens_digit, units_digit
//   wr_*     in   wr_en only    wr_index, wr_data
//
// One event is taken per clock while in_ch.ready is high; its display result is registered into the output queue.
// The phase state updates in the same cycle as the input transfer; the result
// goes into a two-entry output queue, so the input keeps flowing while one
// result waits. in_ch.ready drops only when both queue entries are full.
// Reset: lamps off, display 00, phase logic stopped, configuration at defaults.
`timescale 1ns / 1ps

module two_way_traffic_light_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  twtlc_pkg::reg_idx_t   wr_index,
	input  twtlc_pkg::total_t     wr_data,
	twtlc_in_if.sink              in_ch,
	twtlc_out_if.source           out_ch
);

	import twtlc_pkg::*;

	`include "two_way_traffic_light_controller_assert.svh"

	// Configuration registers
	total_t  south_total_q;
	total_t  west_total_q;
	yellow_t yellow_ticks_q;

	// Phase state
	logic    running_q, running_d;
	logic    phase_west_q, phase_west_d;
	total_t  count_q, count_d;
	logic    ovr_q, ovr_d;
	yellow_t ovr_cnt_q, ovr_cnt_d;
	logic    press_q, press_d;
	lamp_t   lamp_q, lamp_d;
	total_t  shown_q, shown_d;

	// Output queue
	out_item_t   ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;

	logic    in_xfer;
	logic    out_xfer;
	total_t  next_total;
	total_t  count_dec;
	yellow_t ovr_dec;

	assign in_ch.ready = (fill_q != 2'd2);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_xfer    = out_ch.valid && out_ch.ready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			south_total_q  <= SOUTH_TOTAL_RST;
			west_total_q   <= WEST_TOTAL_RST;
			yellow_ticks_q <= YELLOW_TICKS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SOUTH_TOTAL:  south_total_q  <= wr_data;
				REG_WEST_TOTAL:   west_total_q   <= wr_data;
				REG_YELLOW_TICKS: yellow_ticks_q <= wr_data[YellowW-1:0];
				default: ;
			endcase
		end
	end

	assign next_total = phase_west_q ? south_total_q : west_total_q;
	assign count_dec  = count_q - total_t'(1);
	assign ovr_dec    = ovr_cnt_q - yellow_t'(1);

	// Advance the phase state for one event
	always_comb begin
		running_d    = running_q;
		phase_west_d = phase_west_q;
		count_d      = count_q;
		ovr_d        = ovr_q;
		ovr_cnt_d    = ovr_cnt_q;
		press_d      = press_q;
		lamp_d       = lamp_q;
		shown_d      = shown_q;
		if (in_xfer) begin
			unique case (in_ch.kind)
				KIND_START: begin
					if (!running_q) begin
						running_d    = 1'b1;
						ovr_d        = 1'b0;
						ovr_cnt_d    = '0;
						press_d      = 1'b0;
						phase_west_d = 1'b0;
						count_d      = south_total_q;
						lamp_d       = lamp_code(1'b0,
							south_total_q > total_t'(yellow_ticks_q));
						shown_d      = south_total_q;
					end
				end
				KIND_PRESS: begin
					if (running_q && in_ch.manual_enable) begin
						press_d = 1'b1;
					end
				end
				KIND_TICK: begin
					if (running_q) begin
						priority if (ovr_q && ovr_cnt_q <= yellow_t'(1)) begin
							// forced yellow done: hand over to the other direction
							ovr_d        = 1'b0;
							ovr_cnt_d    = '0;
							phase_west_d = !phase_west_q;
							count_d      = next_total;
							lamp_d       = lamp_code(!phase_west_q,
								next_total > total_t'(yellow_ticks_q));
							shown_d      = next_total;
						end else if (ovr_q) begin
							ovr_cnt_d = ovr_dec;
							shown_d   = total_t'(ovr_dec);
						end else if (press_q) begin
							// start the forced yellow countdown
							press_d   = 1'b0;
							ovr_d     = 1'b1;
							ovr_cnt_d = yellow_ticks_q;
							lamp_d    = lamp_code(phase_west_q, 1'b0);
							shown_d   = total_t'(yellow_ticks_q);
						end else if (count_q <= total_t'(1)) begin
							phase_west_d = !phase_west_q;
							count_d      = next_total;
							lamp_d       = lamp_code(!phase_west_q,
								next_total > total_t'(yellow_ticks_q));
							shown_d      = next_total;
						end else begin
							count_d = count_dec;
							lamp_d  = lamp_code(phase_west_q,
								count_dec > total_t'(yellow_ticks_q));
							shown_d = count_dec;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Hold the phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			phase_west_q <= 1'b0;
			count_q      <= '0;
			ovr_q        <= 1'b0;
			ovr_cnt_q    <= '0;
			press_q      <= 1'b0;
			lamp_q       <= LAMP_OFF;
			shown_q      <= '0;
		end else begin
			running_q    <= running_d;
			phase_west_q <= phase_west_d;
			count_q      <= count_d;
			ovr_q        <= ovr_d;
			ovr_cnt_q    <= ovr_cnt_d;
			press_q      <= press_d;
			lamp_q       <= lamp_d;
			shown_q      <= shown_d;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (in_xfer) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (out_xfer) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(in_xfer) - 2'(out_xfer);
		end
	end

	// Store each result with its digits split out
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ent_q[wr_ptr_q] <= '{lamps:       lamp_d,
			                     tens_digit:  tens_of(shown_d),
			                     units_digit: units_of(shown_d)};
		end
	end

	// Drive the result from the queue head
	assign out_ch.valid       = (fill_q != 2'd0);
	assign out_ch.lamps       = ent_q[rd_ptr_q].lamps;
	assign out_ch.tens_digit  = ent_q[rd_ptr_q].tens_digit;
	assign out_ch.units_digit = ent_q[rd_ptr_q].units_digit;

	`TWTLC_ASSERT_NEVER(a_fill_bound, clk, arst_n, fill_q == 2'd3)
	`TWTLC_ASSERT(a_no_push_full, clk, arst_n, in_xfer |-> fill_q != 2'd2)
	`TWTLC_ASSERT(a_dark_when_idle, clk, arst_n, !running_q |-> lamp_q == LAMP_OFF)
	`TWTLC_ASSERT(a_override_yellow, clk, arst_n,
		ovr_q |-> lamp_q == (phase_west_q ? LAMP_W_YELLOW : LAMP_S_YELLOW))
	`TWTLC_ASSERT(a_pending_needs_run, clk, arst_n, press_q |-> running_q)

endmodule

FILE: sim/tb_two_way_traffic_light_controller.sv
// Testbench of the two-way traffic light controller: event stimulus, display prediction and check.
`timescale 1ns / 1ps

module tb_two_way_traffic_light_controller;
	import twtlc_pkg::*;

	localparam kind_code_t KIND_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES = 10;
	localparam int EVENTS_PER_PHASE = 110;

	// Predicts the lamp and countdown display for each event and checks the results
	class light_scoreboard;
		total_t    south_ticks = SOUTH_TOTAL_RST;
		total_t    west_ticks  = WEST_TOTAL_RST;
		yellow_t   yellow_len  = YELLOW_TICKS_RST;
		logic      running     = 1'b0;
		logic      on_west     = 1'b0;
		logic      ovr_on      = 1'b0;
		logic      press_held  = 1'b0;
		total_t    count       = '0;
		total_t    shown       = '0;
		yellow_t   ovr_count   = '0;
		lamp_t     lamps       = LAMP_OFF;
		out_item_t display_queue[$];
		int        errors      = 0;

		function void set_reg(reg_sel_t idx, total_t data);
			case (idx)
				REG_SOUTH_TOTAL: south_ticks = data;
				REG_WEST_TOTAL: west_ticks = data;
				REG_YELLOW_TICKS: yellow_len = data[3:0];
				default: ;
			endcase
		endfunction

		// Green while the count stays above the yellow length
		function void show_count();
			if (on_west) begin
				lamps = (count > yellow_len) ? LAMP_W_GREEN : LAMP_W_YELLOW;
			end else begin
				lamps = (count > yellow_len) ? LAMP_S_GREEN : LAMP_S_YELLOW;
			end
			shown = count;
		endfunction

		function void enter_phase(logic west);
			on_west = west;
			count = west ? west_ticks : south_ticks;
			show_count();
		endfunction

		function void note_event(kind_code_t k, logic man);
			out_item_t item;
			if (k == KIND_START) begin
				if (!running) begin
					running = 1'b1;
					ovr_on = 1'b0;
					ovr_count = '0;
					press_held = 1'b0;
					enter_phase(1'b0);
				end
			end else if (k == KIND_PRESS) begin
				if (running && man) press_held = 1'b1;
			end else if (k == KIND_TICK && running) begin
				if (ovr_on) begin
					// forced yellow countdown; hand over to the other direction at its end
					if (ovr_count <= 1) begin
						ovr_on = 1'b0;
						ovr_count = '0;
						enter_phase(!on_west);
					end else begin
						ovr_count = ovr_count - 1'b1;
						shown = total_t'(ovr_count);
					end
				end else if (press_held) begin
					press_held = 1'b0;
					ovr_on = 1'b1;
					ovr_count = yellow_len;
					lamps = on_west ? LAMP_W_YELLOW : LAMP_S_YELLOW;
					shown = total_t'(ovr_count);
				end else if (count <= 1) begin
					enter_phase(!on_west);
				end else begin
					count = count - 1'b1;
					show_count();
				end
			end
			item.lamps = lamps;
			item.tens_digit = digit_t'(shown / 10);
			item.units_digit = digit_t'(shown % 10);
			display_queue.push_back(item);
		endfunction

		function void check_display(out_item_t got);
			out_item_t want;
			if (display_queue.size() == 0) begin
				$error("result with nothing expected: lamps %0h tens %0d units %0d",
					got.lamps, got.tens_digit, got.units_digit);
				errors++;
				return;
			end
			want = display_queue.pop_front();
			if (got.lamps !== want.lamps) begin
				$error("lamps: expected %b, got %b", want.lamps, got.lamps);
				errors++;
			end
			if (got.tens_digit !== want.tens_digit) begin
				$error("tens_digit: expected %0d, got %0d", want.tens_digit, got.tens_digit);
				errors++;
			end
			if (got.units_digit !== want.units_digit) begin
				$error("units_digit: expected %0d, got %0d", want.units_digit, got.units_digit);
				errors++;
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     wr_en;
	reg_idx_t wr_index;
	total_t   wr_data;

	twtlc_in_if  in_ch ();
	twtlc_out_if out_ch ();

	two_way_traffic_light_controller i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	light_scoreboard sb = new;
	int burst_left = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int stall_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Note each accepted event and check each accepted display
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) sb.note_event(in_ch.kind, in_ch.manual_enable);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check_display(out_item_t'({out_ch.lamps, out_ch.tens_digit, out_ch.units_digit}));
		end
	end

	// Stall the display side, switching among four stall patterns at random
	always @(posedge clk) begin
		if (stall_cycles == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_cycles <= $urandom_range(50, 300);
		end else begin
			stall_cycles <= stall_cycles - 1;
		end
		case (stall_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= 1'($urandom_range(0, 1));
			2: out_ch.ready <= (stall_cycles % 4 == 0);
			default: out_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Drop the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles = idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Present one event in bursts with random gaps; return after its transfer
	task automatic send_event(kind_code_t k, logic man);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= k;
		in_ch.manual_enable <= man;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		burst_left--;
	endtask

	// Hold the input idle until every display has come out, then settle
	task automatic wait_drained(int settle);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.display_queue.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// Write all three timing registers on back-to-back cycles
	task automatic set_timing(total_t south, total_t west, total_t yellow_data);
		wr_en <= 1'b1;
		wr_index <= REG_SOUTH_TOTAL;
		wr_data <= south;
		@(posedge clk);
		sb.set_reg(REG_SOUTH_TOTAL, south);
		wr_index <= REG_WEST_TOTAL;
		wr_data <= west;
		@(posedge clk);
		sb.set_reg(REG_WEST_TOTAL, west);
		wr_index <= REG_YELLOW_TICKS;
		wr_data <= yellow_data;
		@(posedge clk);
		sb.set_reg(REG_YELLOW_TICKS, yellow_data);
		wr_en <= 1'b0;
	endtask

	task automatic send_random_event();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 78) begin
			send_event(KIND_TICK, 1'($urandom_range(0, 1)));
		end else if (pick < 90) begin
			send_event(KIND_PRESS, $urandom_range(0, 3) != 0);
		end else if (pick < 95) begin
			send_event(KIND_START, 1'($urandom_range(0, 1)));
		end else begin
			send_event(KIND_NONE, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		total_t south;
		total_t west;
		total_t yellow_data;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_TICK;
		in_ch.manual_enable = 1'b0;
		out_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ignored events before start, a repeated start, presses and overrides at reset timing
		send_event(KIND_TICK, 1'b0);
		send_event(KIND_PRESS, 1'b1);
		send_event(KIND_NONE, 1'b1);
		send_event(KIND_TICK, 1'b1);
		send_event(KIND_START, 1'b0);
		send_event(KIND_START, 1'b1);
		repeat (3) send_event(KIND_TICK, 1'b0);
		send_event(KIND_PRESS, 1'b0);
		send_event(KIND_NONE, 1'b0);
		send_event(KIND_PRESS, 1'b1);
		send_event(KIND_PRESS, 1'b1);
		send_event(KIND_TICK, 1'b0);
		send_event(KIND_PRESS, 1'b1);
		repeat (8) send_event(KIND_TICK, 1'b1);
		wait_drained(3);

		// Random events under several timing settings, extremes first
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					south = 7'd0;
					west = 7'd0;
					yellow_data = 7'd0;
				end
				1: begin
					south = 7'd127;
					west = 7'd127;
					yellow_data = 7'h7F;
				end
				2: begin
					south = 7'd1;
					west = 7'd1;
					yellow_data = 7'd1;
				end
				3: begin
					south = 7'd99;
					west = 7'd99;
					yellow_data = 7'd9;
				end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						south = total_t'($urandom_range(0, 127));
						west = total_t'($urandom_range(0, 127));
					end else begin
						south = total_t'($urandom_range(0, 25));
						west = total_t'($urandom_range(0, 25));
					end
					yellow_data = total_t'($urandom_range(0, 127));
				end
			endcase
			set_timing(south, west, yellow_data);
			repeat (EVENTS_PER_PHASE) send_random_event();
			wait_drained(3);
		end

		wait_drained(10);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
